/* sv/rps_pkg.sv */
// Shared types, codes and constants of the point rotate-scale-translate block.
`default_nettype none

package rps_pkg;

	// Fixed field widths.
	localparam int COORD_BITS = 16;
	localparam int POINT_W    = 16;
	localparam int SCALE_W    = 24;
	localparam int OFFSET_W   = 16;
	localparam int ROT_STEP_W = 12;
	localparam int ZOOM_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Datapath widths.
	localparam int TRIG_W     = 16;
	localparam int TRIG_MAG_W = 15;
	localparam int TPROD_W    = 31;
	localparam int MPROD_W    = TPROD_W + SCALE_W + 1;
	localparam int FRAC_SHIFT = 30;
	localparam int RND_W      = MPROD_W - FRAC_SHIFT;
	localparam int PIX_SUM_W  = RND_W + 1;
	localparam int ZOOM_SHIFT = 16;
	localparam int STEP_W     = 3;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;
	localparam logic signed [MPROD_W-1:0] RND_HALF = MPROD_W'(64'sd1 <<< (FRAC_SHIFT - 1));
	localparam logic signed [COORD_BITS-1:0] PIX_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] PIX_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
	localparam longint ONE_Q30 = 64'sd1073741824;

	// Last step of each sequenced operation.
	localparam logic [STEP_W-1:0] MAC_LAST  = 3'd5;
	localparam logic [STEP_W-1:0] ZOOM_LAST = 3'd3;

	// Action codes of an input beat.
	localparam logic [1:0] ACT_POINT   = 2'd0;
	localparam logic [1:0] ACT_ROTATE  = 2'd1;
	localparam logic [1:0] ACT_ZOOM    = 2'd2;
	localparam logic [1:0] ACT_RESTART = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_SCALE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SCALE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_STEP     = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [SCALE_W-1:0]         RST_START_SCALE = 24'd256;
	localparam logic signed [OFFSET_W-1:0] RST_OFFSET      = 16'sd0;
	localparam logic [ROT_STEP_W-1:0]      RST_ROT_STEP    = 12'd4;
	localparam logic [ZOOM_W-1:0]          RST_ZOOM_STEP   = 16'd655;

	typedef struct packed {
		logic [1:0]                 action;
		logic signed [POINT_W-1:0]  point_x;
		logic signed [POINT_W-1:0]  point_y;
		logic                       direction;
	} in_beat_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic                         clipped;
	} out_beat_t;

	typedef struct packed {
		logic [SCALE_W-1:0]         start_scale_x;
		logic [SCALE_W-1:0]         start_scale_y;
		logic signed [OFFSET_W-1:0] offset_x;
		logic signed [OFFSET_W-1:0] offset_y;
		logic [ROT_STEP_W-1:0]      rotation_step;
		logic [ZOOM_W-1:0]          zoom_step;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_POINT,
		OP_ROTATE,
		OP_ZOOM,
		OP_RESTART
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [POINT_W-1:0]  point_x;
		logic signed [POINT_W-1:0]  point_y;
		logic                       direction;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOOKUP,
		BK_MAC,
		BK_ROUND,
		BK_EMIT,
		BK_ZOOM
	} back_state_t;

	typedef enum logic [2:0] {
		T_HOLD,
		T_CS_PX,
		T_SN_PY,
		T_SN_PX,
		T_CS_PY,
		T_ZOOM
	} t_src_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_X_LOAD,
		ACC_X_ADD,
		ACC_Y_LOAD,
		ACC_Y_SUB
	} acc_op_t;

	typedef struct packed {
		logic    pop;
		logic    push;
		logic    trig_ld;
		logic    round_ld;
		t_src_t  t_src;
		logic    m_en;
		logic    m_use_y;
		acc_op_t acc_op;
		logic    zoom_wr_x;
		logic    zoom_wr_y;
	} bk_ctl_t;

	// Q2.30 product, truncated toward zero.
	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b) / ONE_Q30;
	endfunction

endpackage

`default_nettype wire

/* sv/rps_fifo.sv */
// Small first-in first-out queue of register entries.
`default_nettype none

module rps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

/* sv/rps_front.sv */
// Front end: accepts input beats, classifies the action and queues commands.
`default_nettype none

module rps_front #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rps_pkg::in_beat_t cmd,
	input  logic              pop,
	output logic              empty,
	output rps_pkg::cmd_t     head
);
	import rps_pkg::*;

	cmd_t classified;

	always_comb begin
		classified.point_x   = cmd.point_x;
		classified.point_y   = cmd.point_y;
		classified.direction = cmd.direction;
		unique case (cmd.action)
			ACT_POINT:   classified.op = OP_POINT;
			ACT_ROTATE:  classified.op = OP_ROTATE;
			ACT_ZOOM:    classified.op = OP_ZOOM;
			ACT_RESTART: classified.op = OP_RESTART;
			default:     classified.op = OP_POINT;
		endcase
	end

	rps_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(classified),
		.full   (full),
		.rd_en  (pop),
		.rd_data(head),
		.empty  (empty)
	);

endmodule

`default_nettype wire

/* sv/rps_back.sv */
// Back end: holds angle and scales; sequences point and zoom on a shared multiplier pair.
`default_nettype none

module rps_back #(
	parameter int ANGLE_BITS   = 12,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rps_pkg::cfg_t      cfg,
	input  logic               cq_empty,
	input  rps_pkg::cmd_t      cq_head,
	output logic               cq_pop,
	input  logic               rq_full,
	output logic               rq_push,
	output rps_pkg::out_beat_t rq_data
);
	import rps_pkg::*;

	localparam int QB = ANGLE_BITS - 2;
	localparam int IW = $clog2(SINE_ENTRIES);
	localparam int KW = QB + $clog2(SINE_ENTRIES + 1);

	typedef logic [TRIG_MAG_W-1:0] rom_t [SINE_ENTRIES];

	typedef struct packed {
		logic [IW-1:0] idx;
		logic          full;
		logic          neg;
	} trig_addr_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] val;
		logic                         clip;
	} sat_t;

	// Quarter-wave sine, odd ninth-order polynomial in Q2.30, rounded to Q1.14.
	function automatic rom_t build_rom();
		rom_t   t;
		longint u;
		longint u2;
		longint p;
		longint s;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			u  = (longint'(i) * ONE_Q30) / SINE_ENTRIES;
			u2 = mul_q30(u, u);
			p  = 64'sd172272;
			p  = -64'sd5026995 + mul_q30(p, u2);
			p  = 64'sd85569306 + mul_q30(p, u2);
			p  = -64'sd693598669 + mul_q30(p, u2);
			p  = 64'sd1686629713 + mul_q30(p, u2);
			s  = mul_q30(p, u);
			if (s <= 0) begin
				t[i] = '0;
			end else begin
				s = (s + 64'sd32768) / 64'sd65536;
				if (s > 64'sd16384) begin
					s = 64'sd16384;
				end
				t[i] = TRIG_MAG_W'(s);
			end
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	function automatic trig_addr_t trig_addr(input logic [1:0] q, input logic [QB-1:0] r);
		trig_addr_t t;
		logic [QB-1:0] k;
		logic [KW-1:0] prod;
		// Odd quadrants mirror the table; a full quarter reads as one.
		k      = q[0] ? (~r + 1'b1) : r;
		prod   = KW'(k) * KW'(SINE_ENTRIES);
		t.idx  = IW'(prod >> QB);
		t.full = q[0] && (r == '0);
		t.neg  = q[1];
		return t;
	endfunction

	function automatic logic signed [TRIG_W-1:0] trig_val(input logic [TRIG_MAG_W-1:0] m,
			input logic full, input logic neg);
		logic signed [TRIG_W-1:0] v;
		v = full ? TRIG_ONE : signed'({1'b0, m});
		return neg ? -v : v;
	endfunction

	function automatic sat_t sat_pix(input logic signed [PIX_SUM_W-1:0] v);
		sat_t s;
		if (v > PIX_SUM_W'(PIX_MAX)) begin
			s.val  = PIX_MAX;
			s.clip = 1'b1;
		end else if (v < PIX_SUM_W'(PIX_MIN)) begin
			s.val  = PIX_MIN;
			s.clip = 1'b1;
		end else begin
			s.val  = v[COORD_BITS-1:0];
			s.clip = 1'b0;
		end
		return s;
	endfunction

	function automatic logic [SCALE_W-1:0] zoom_upd(input logic [SCALE_W-1:0] s,
			input logic signed [MPROD_W-1:0] m, input logic zoom_in);
		logic [SCALE_W-1:0] d;
		logic [SCALE_W:0]   n;
		d = m[SCALE_W+ZOOM_SHIFT-1:ZOOM_SHIFT];
		n = {1'b0, s} + {1'b0, d};
		if (zoom_in) begin
			return n[SCALE_W] ? {SCALE_W{1'b1}} : n[SCALE_W-1:0];
		end
		return s - d;
	endfunction

	back_state_t state_q;
	back_state_t state_d;
	bk_ctl_t     ctl;
	logic [STEP_W-1:0] step_q;

	logic [ANGLE_BITS-1:0] angle_q;
	logic [ANGLE_BITS-1:0] rot_step;
	logic [SCALE_W-1:0]    scale_x_q;
	logic [SCALE_W-1:0]    scale_y_q;
	cmd_t                  cmd_q;

	trig_addr_t sin_a;
	trig_addr_t cos_a;
	logic [TRIG_MAG_W-1:0] sin_m_q;
	logic [TRIG_MAG_W-1:0] cos_m_q;
	logic sin_full_q;
	logic sin_neg_q;
	logic cos_full_q;
	logic cos_neg_q;
	logic signed [TRIG_W-1:0] sn_q;
	logic signed [TRIG_W-1:0] cs_q;

	logic signed [TPROD_W-1:0] t_q;
	logic signed [SCALE_W:0]   m_b;
	logic signed [MPROD_W-1:0] m_prod;
	logic signed [MPROD_W-1:0] m_q;
	logic signed [MPROD_W-1:0] acc_x_q;
	logic signed [MPROD_W-1:0] acc_y_q;
	logic signed [MPROD_W-1:0] bias_x;
	logic signed [MPROD_W-1:0] bias_y;
	logic signed [RND_W-1:0]   rnd_x_q;
	logic signed [RND_W-1:0]   rnd_y_q;
	sat_t sat_x;
	sat_t sat_y;

	assign rot_step = ANGLE_BITS'(cfg.rotation_step);

	// Sine and cosine addresses; cosine is a quarter turn ahead.
	assign sin_a = trig_addr(angle_q[ANGLE_BITS-1 -: 2], angle_q[QB-1:0]);
	assign cos_a = trig_addr(angle_q[ANGLE_BITS-1 -: 2] + 2'd1, angle_q[QB-1:0]);

	always_ff @(posedge clk) begin
		sin_m_q    <= SINE_ROM[sin_a.idx];
		cos_m_q    <= SINE_ROM[cos_a.idx];
		sin_full_q <= sin_a.full;
		sin_neg_q  <= sin_a.neg;
		cos_full_q <= cos_a.full;
		cos_neg_q  <= cos_a.neg;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cq_empty) begin
					unique case (cq_head.op) inside
						OP_POINT:               state_d = BK_LOOKUP;
						OP_ZOOM:                state_d = BK_ZOOM;
						OP_ROTATE, OP_RESTART:  state_d = BK_IDLE;
						default:                state_d = BK_IDLE;
					endcase
				end
			end
			BK_LOOKUP: state_d = BK_MAC;
			BK_MAC: begin
				if (step_q == MAC_LAST) begin
					state_d = BK_ROUND;
				end
			end
			BK_ROUND: state_d = BK_EMIT;
			BK_EMIT: begin
				if (!rq_full) begin
					state_d = BK_IDLE;
				end
			end
			BK_ZOOM: begin
				if (step_q == ZOOM_LAST) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control decode per state and step.
	always_comb begin
		ctl = '{pop: 1'b0, push: 1'b0, trig_ld: 1'b0, round_ld: 1'b0, t_src: T_HOLD,
			m_en: 1'b0, m_use_y: 1'b0, acc_op: ACC_NONE, zoom_wr_x: 1'b0, zoom_wr_y: 1'b0};
		unique case (state_q)
			BK_IDLE:   ctl.pop = !cq_empty;
			BK_LOOKUP: ctl.trig_ld = 1'b1;
			BK_MAC: begin
				case (step_q)
					3'd0: ctl.t_src = T_CS_PX;
					3'd1: begin
						ctl.t_src = T_SN_PY;
						ctl.m_en  = 1'b1;
					end
					3'd2: begin
						ctl.t_src   = T_SN_PX;
						ctl.m_en    = 1'b1;
						ctl.m_use_y = 1'b1;
						ctl.acc_op  = ACC_X_LOAD;
					end
					3'd3: begin
						ctl.t_src  = T_CS_PY;
						ctl.m_en   = 1'b1;
						ctl.acc_op = ACC_X_ADD;
					end
					3'd4: begin
						ctl.m_en    = 1'b1;
						ctl.m_use_y = 1'b1;
						ctl.acc_op  = ACC_Y_LOAD;
					end
					3'd5: ctl.acc_op = ACC_Y_SUB;
					default: ctl.acc_op = ACC_NONE;
				endcase
			end
			BK_ROUND: ctl.round_ld = 1'b1;
			BK_EMIT:  ctl.push = !rq_full;
			BK_ZOOM: begin
				case (step_q)
					3'd0: ctl.t_src = T_ZOOM;
					3'd1: ctl.m_en = 1'b1;
					3'd2: begin
						ctl.m_en      = 1'b1;
						ctl.m_use_y   = 1'b1;
						ctl.zoom_wr_x = 1'b1;
					end
					3'd3: ctl.zoom_wr_y = 1'b1;
					default: ctl.zoom_wr_y = 1'b0;
				endcase
			end
			default: ctl.pop = 1'b0;
		endcase
	end

	assign cq_pop  = ctl.pop;
	assign rq_push = ctl.push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			step_q    <= '0;
			angle_q   <= '0;
			scale_x_q <= RST_START_SCALE;
			scale_y_q <= RST_START_SCALE;
		end else begin
			state_q <= state_d;
			if ((state_q == BK_MAC || state_q == BK_ZOOM) && state_d == state_q) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (ctl.pop) begin
				case (cq_head.op)
					OP_ROTATE: begin
						angle_q <= cq_head.direction ? angle_q + rot_step : angle_q - rot_step;
					end
					OP_RESTART: begin
						angle_q   <= '0;
						scale_x_q <= cfg.start_scale_x;
						scale_y_q <= cfg.start_scale_y;
					end
					default: angle_q <= angle_q;
				endcase
			end
			if (ctl.zoom_wr_x) begin
				scale_x_q <= zoom_upd(scale_x_q, m_q, cmd_q.direction);
			end
			if (ctl.zoom_wr_y) begin
				scale_y_q <= zoom_upd(scale_y_q, m_q, cmd_q.direction);
			end
		end
	end

	// Second multiplier: trig-by-coordinate product, or the zoom step, times an axis scale.
	assign m_b    = signed'({1'b0, ctl.m_use_y ? scale_y_q : scale_x_q});
	assign m_prod = t_q * m_b;

	assign bias_x = acc_x_q + RND_HALF;
	assign bias_y = acc_y_q + RND_HALF;
	assign sat_x  = sat_pix(PIX_SUM_W'(rnd_x_q) + PIX_SUM_W'(cfg.offset_x));
	assign sat_y  = sat_pix(PIX_SUM_W'(rnd_y_q) + PIX_SUM_W'(cfg.offset_y));

	always_comb begin
		rq_data.pixel_x = sat_x.val;
		rq_data.pixel_y = sat_y.val;
		rq_data.clipped = sat_x.clip || sat_y.clip;
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cmd_q <= cq_head;
		end
		if (ctl.trig_ld) begin
			sn_q <= trig_val(sin_m_q, sin_full_q, sin_neg_q);
			cs_q <= trig_val(cos_m_q, cos_full_q, cos_neg_q);
		end
		case (ctl.t_src)
			T_CS_PX: t_q <= TPROD_W'(cs_q) * TPROD_W'(cmd_q.point_x);
			T_SN_PY: t_q <= TPROD_W'(sn_q) * TPROD_W'(cmd_q.point_y);
			T_SN_PX: t_q <= TPROD_W'(sn_q) * TPROD_W'(cmd_q.point_x);
			T_CS_PY: t_q <= TPROD_W'(cs_q) * TPROD_W'(cmd_q.point_y);
			T_ZOOM:  t_q <= TPROD_W'({1'b0, cfg.zoom_step});
			default: t_q <= t_q;
		endcase
		if (ctl.m_en) begin
			m_q <= m_prod;
		end
		case (ctl.acc_op)
			ACC_X_LOAD: acc_x_q <= m_q;
			ACC_X_ADD:  acc_x_q <= acc_x_q + m_q;
			ACC_Y_LOAD: acc_y_q <= m_q;
			ACC_Y_SUB:  acc_y_q <= acc_y_q - m_q;
			default:    acc_x_q <= acc_x_q;
		endcase
		if (ctl.round_ld) begin
			// Round half up to whole pixels: add one half, keep the integer part.
			rnd_x_q <= bias_x[MPROD_W-1:FRAC_SHIFT];
			rnd_y_q <= bias_y[MPROD_W-1:FRAC_SHIFT];
		end
	end

endmodule

`default_nettype wire

/* sv/point_rotate_scale_transform_unit.sv */
// Top level of the point rotate-scale-translate block: configuration, queues and checks.
//
// Usage. Commands arrive on a queue-style port: a beat on cmd is taken at a clock edge
// with push high and full low. Action point transforms (point_x, point_y) and yields one
// beat on pixel; rotate, zoom and restart change the held angle or scales and yield none.
// Results leave through a second queue: while empty is low the oldest beat is on pixel,
// and it is taken at an edge with pop high. Configuration writes use cfg_valid/cfg_ready
// (ready is always high) with cfg_index selecting the register; indexes past the last
// register are ignored. Write configuration only while the block has no command in flight.
// A point beat reaches pixel through the command queue, the back end and the result queue.
// The back end owns one point at a time: a dual-port sine table read, six steps through
// a 16x16 and a 31x25 multiplier, rounding, and output once the result queue has room.
// Rotate and restart act as the command is popped; zoom runs one multiplier pass per axis.
// The command queue keeps accepting beats while the back end works, until it fills.
// Reset puts the angle at zero, both scales at 1/256 (Q8.16) and all registers at defaults;
// both queues come up empty. When the receiver stalls, results collect in the result queue,
// then the back end holds its finished beat, and the command queue fills and raises full.
`default_nettype none

module point_rotate_scale_transform_unit #(
	parameter int ANGLE_BITS   = 12,
	parameter int SINE_ENTRIES = 1024,
	parameter int CMD_DEPTH    = 2,
	parameter int RES_DEPTH    = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  rps_pkg::in_beat_t                  cmd,
	output logic                               empty,
	input  logic                               pop,
	output rps_pkg::out_beat_t                 pixel,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rps_pkg::*;

	cfg_t      cfg_q;
	logic      cq_empty;
	logic      cq_pop;
	cmd_t      cq_head;
	logic      rq_full;
	logic      rq_push;
	out_beat_t rq_data;

	// Register writes are taken whenever valid is high, so the channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_scale_x <= RST_START_SCALE;
			cfg_q.start_scale_y <= RST_START_SCALE;
			cfg_q.offset_x      <= RST_OFFSET;
			cfg_q.offset_y      <= RST_OFFSET;
			cfg_q.rotation_step <= RST_ROT_STEP;
			cfg_q.zoom_step     <= RST_ZOOM_STEP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_SCALE_X: cfg_q.start_scale_x <= cfg_data[SCALE_W-1:0];
				REG_START_SCALE_Y: cfg_q.start_scale_y <= cfg_data[SCALE_W-1:0];
				REG_OFFSET_X:      cfg_q.offset_x      <= signed'(cfg_data[OFFSET_W-1:0]);
				REG_OFFSET_Y:      cfg_q.offset_y      <= signed'(cfg_data[OFFSET_W-1:0]);
				REG_ROTATION_STEP: cfg_q.rotation_step <= cfg_data[ROT_STEP_W-1:0];
				REG_ZOOM_STEP:     cfg_q.zoom_step     <= cfg_data[ZOOM_W-1:0];
				default:           cfg_q.zoom_step     <= cfg_q.zoom_step;
			endcase
		end
	end

	// Front end: classifies each input beat and buffers it for the back end.
	rps_front #(
		.DEPTH(CMD_DEPTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.cmd   (cmd),
		.pop   (cq_pop),
		.empty (cq_empty),
		.head  (cq_head)
	);

	// Back end: holds the transform state and executes one command at a time.
	rps_back #(
		.ANGLE_BITS  (ANGLE_BITS),
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cq_empty(cq_empty),
		.cq_head (cq_head),
		.cq_pop  (cq_pop),
		.rq_full (rq_full),
		.rq_push (rq_push),
		.rq_data (rq_data)
	);

	// Result queue decouples the back end from a stalling receiver.
	rps_fifo #(
		.WIDTH($bits(out_beat_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rq_push),
		.wr_data(rq_data),
		.full   (rq_full),
		.rd_en  (pop),
		.rd_data(pixel),
		.empty  (empty)
	);

`ifndef SYNTHESIS
	// The back end must never hand a result to a full result queue.
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> !rq_full)
		else $error("result written into a full queue");

	// The back end takes a command only when the front end has one.
	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("command taken from an empty queue");

	// A clipped result always sits on a rail of the pixel range.
	a_clip_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pixel.clipped) |->
		(pixel.pixel_x == PIX_MAX || pixel.pixel_x == PIX_MIN ||
		 pixel.pixel_y == PIX_MAX || pixel.pixel_y == PIX_MIN))
		else $error("clipped flag without a saturated coordinate");
`endif

endmodule

`default_nettype wire
